FILE: src/kalman_angle_bias_filter_assert.svh
// Assertion macros for the angle and bias filter checks.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH

// Check a consequent in the same cycle as the antecedent.
`define KAB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kab check failed");

// Check a consequent in the cycle after the antecedent.
`define KAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kab check failed");

`endif

FILE: src/kab_pkg.sv
package kab_pkg;

	localparam int StW      = 32;
	localparam int CovW     = 48;
	localparam int NoiseW   = 47;
	localparam int DtW      = 32;
	localparam int MulXW    = 63;
	localparam int MulYW    = 48;
	localparam int MulAccW  = MulXW + MulYW;
	localparam int MulCntW  = $clog2(MulYW);
	localparam int DivQW    = 62;
	localparam int DivCntW  = $clog2(DivQW);
	localparam int ResW     = 64;
	localparam int CfgIdxW  = 2;

	localparam logic [MulXW-1:0] MagLimit = MulXW'(1) << 62;
	localparam logic [MulXW-1:0] HalfDt   = MulXW'(1) << 31;
	localparam logic [MulXW-1:0] HalfCov  = MulXW'(1) << 43;

	localparam logic [NoiseW-1:0] QAngleRst = NoiseW'(47'd1759218604);
	localparam logic [NoiseW-1:0] QBiasRst  = NoiseW'(47'd527765581);
	localparam logic [NoiseW-1:0] RMeasRst  = NoiseW'(47'd527765581332);
	localparam logic [DtW-1:0]    DtRst     = DtW'(32'd21474836);
	localparam logic [CovW-1:0]   CovOne    = CovW'(1) << 44;

	localparam logic [CfgIdxW-1:0] CFG_Q_ANGLE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_Q_BIAS  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_R_MEAS  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_STEP    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_ANG,
		ST_P_AA,
		ST_P_OFF,
		ST_P_BB,
		ST_E_CHK,
		ST_D_K0,
		ST_D_K1,
		ST_C_BA,
		ST_C_BB,
		ST_C_AA,
		ST_C_AB,
		ST_C_ANG,
		ST_C_BIAS,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [MulXW-1:0] x;
		logic [MulYW-1:0] y;
		logic             neg;
		logic             frac_hi;
	} mul_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [ResW-1:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic                   start;
		logic signed [CovW-1:0] num;
		logic [CovW-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [MulXW-1:0] mag;
	} div_rsp_t;

	function automatic logic signed [StW-1:0] sat_add32(input logic signed [StW-1:0] a,
			input logic signed [ResW-1:0] d);
		logic [ResW:0] s;
		s = {{(ResW-StW+1){a[StW-1]}}, a} + {d[ResW-1], d};
		if (s[ResW:StW-1] != {(ResW-StW+2){s[ResW]}})
			return s[ResW] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
		return s[StW-1:0];
	endfunction

	function automatic logic signed [CovW-1:0] sat_add48(input logic signed [CovW-1:0] a,
			input logic signed [ResW-1:0] d);
		logic [ResW:0] s;
		s = {{(ResW-CovW+1){a[CovW-1]}}, a} + {d[ResW-1], d};
		if (s[ResW:CovW-1] != {(ResW-CovW+2){s[ResW]}})
			return s[ResW] ? {1'b1, {(CovW-1){1'b0}}} : {1'b0, {(CovW-1){1'b1}}};
		return s[CovW-1:0];
	endfunction

endpackage

FILE: src/kab_mul.sv
module kab_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  kab_pkg::mul_req_t req,
	output kab_pkg::mul_rsp_t rsp
);
	import kab_pkg::*;

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [MulCntW-1:0] cnt_q;
	logic [MulAccW-1:0] acc_q;
	logic [MulXW-1:0]   x_q;
	logic               neg_q;
	logic               hi_q;
	logic signed [ResW-1:0] res_q;

	logic [MulXW:0]     sum;
	logic [78:0]        rsh;
	logic               ovf;
	logic [MulXW-1:0]   mag;

	always_comb begin
		sum = {1'b0, acc_q[MulAccW-1:MulYW]} + {1'b0, (acc_q[0] ? x_q : '0)};
		rsh = hi_q ? {12'b0, acc_q[MulAccW-1:44]} : acc_q[MulAccW-1:32];
		ovf = (|rsh[78:63]) || (rsh[62] && (|rsh[61:0]));
		mag = ovf ? MagLimit : rsh[62:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MulCntW'(MulYW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= {(req.frac_hi ? HalfCov : HalfDt), req.y};
			x_q   <= req.x;
			neg_q <= req.neg;
			hi_q  <= req.frac_hi;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MulYW-1:1]};
		end
		if (fin_q)
			res_q <= neg_q ? -{1'b0, mag} : {1'b0, mag};
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

FILE: src/kab_div.sv
module kab_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kab_pkg::div_req_t req,
	output kab_pkg::div_rsp_t rsp
);
	import kab_pkg::*;

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [CovW-1:0]    rem_q;
	logic [DivQW-1:0]   nb_q;
	logic [DivQW-1:0]   quo_q;
	logic [CovW-1:0]    den_q;
	logic               neg_q;
	logic               ovf_q;
	logic               rneg_q;
	logic [MulXW-1:0]   mag_q;

	logic [CovW-1:0]    n_mag;
	logic [CovW:0]      r2;
	logic               ge;
	logic               rnd;

	always_comb begin
		n_mag = req.num[CovW-1] ? CovW'(-req.num) : CovW'(req.num);
		r2    = {rem_q, nb_q[DivQW-1]};
		ge    = r2 >= {1'b0, den_q};
		rnd   = {rem_q, 1'b0} >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivQW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ovf_q <= {18'b0, n_mag} >= {req.den, 18'b0};
			rem_q <= CovW'(n_mag >> 18);
			nb_q  <= {n_mag[17:0], 44'b0};
			den_q <= req.den;
			neg_q <= req.num[CovW-1];
		end else if (busy_q) begin
			rem_q <= ge ? CovW'(r2 - {1'b0, den_q}) : r2[CovW-1:0];
			quo_q <= {quo_q[DivQW-2:0], ge};
			nb_q  <= {nb_q[DivQW-2:0], 1'b0};
		end
		if (fin_q) begin
			mag_q  <= ovf_q ? MagLimit : ({1'b0, quo_q} + MulXW'(rnd));
			rneg_q <= neg_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = rneg_q;
	assign rsp.mag  = mag_q;

endmodule

FILE: src/kalman_angle_bias_filter.sv
// Two-state tilt filter: each accepted sample (gyro_rate, accel_angle) runs a predict and
// correct pass on the angle, the gyro bias and the 2x2 covariance, and returns one result
// (angle_estimate, rate_estimate). All products and divisions go through one bit-serial
// multiplier and one bit-serial divider (62 quotient bits). A sample takes 10 products and
// 2 divisions, or 4 products when the innovation variance is not positive and the
// correction is skipped. One sample is in work at a time; the finished result sits in an
// output register, so the next sample is taken while it waits.
// Configuration writes are taken at any time but only apply cleanly while idle.
module kalman_angle_bias_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [kab_pkg::StW-1:0]     gyro_rate,
	input  logic signed [kab_pkg::StW-1:0]     accel_angle,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [kab_pkg::StW-1:0]     angle_estimate,
	output logic signed [kab_pkg::StW-1:0]     rate_estimate,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kab_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [kab_pkg::NoiseW-1:0]         cfg_data
);
	import kab_pkg::*;

	state_t state_q, state_d;
	logic   phase_q;

	logic [NoiseW-1:0] qa_q, qb_q, rm_q;
	logic [DtW-1:0]    dt_q;

	logic signed [StW-1:0]  angle_q, bias_q;
	logic signed [CovW-1:0] aa_q, ab_q, ba_q, bb_q;
	logic signed [StW-1:0]  gyro_q, accel_q;
	logic signed [StW:0]    innov_q;
	logic [CovW-1:0]        e_q;
	logic                   k0_neg_q, k1_neg_q;
	logic [MulXW-1:0]       k0_mag_q, k1_mag_q;

	logic                   out_valid_q;
	logic signed [StW-1:0]  angle_out_q, rate_out_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [StW:0]    gb, innov;
	logic [StW:0]           gb_mag, innov_mag;
	logic signed [49:0]     daa;
	logic [49:0]            daa_mag;
	logic [CovW-1:0]        aa_mag, ab_mag, bb_mag;
	logic signed [CovW:0]   e_sum;
	logic                   e_pos;
	logic signed [StW-1:0]  rate_sat;
	logic                   accept, out_load, is_mul, is_div;

	always_comb begin
		gb        = {gyro_q[StW-1], gyro_q} - {bias_q[StW-1], bias_q};
		gb_mag    = gb[StW] ? (StW+1)'(-gb) : gb;
		innov     = {accel_q[StW-1], accel_q} - {angle_q[StW-1], angle_q};
		innov_mag = innov_q[StW] ? (StW+1)'(-innov_q) : innov_q;
		daa       = {3'b0, qa_q} - {{2{ab_q[CovW-1]}}, ab_q} - {{2{ba_q[CovW-1]}}, ba_q};
		daa_mag   = daa[49] ? 50'(-daa) : daa;
		aa_mag    = aa_q[CovW-1] ? CovW'(-aa_q) : aa_q;
		ab_mag    = ab_q[CovW-1] ? CovW'(-ab_q) : ab_q;
		bb_mag    = bb_q[CovW-1] ? CovW'(-bb_q) : bb_q;
		e_sum     = {2'b0, rm_q} + {aa_q[CovW-1], aa_q};
		e_pos     = !e_sum[CovW] && (e_sum != '0);
		if (gb[StW] != gb[StW-1])
			rate_sat = gb[StW] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
		else
			rate_sat = gb[StW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (sample_valid) state_d = ST_P_ANG;
			ST_P_ANG:  if (mul_rsp.done) state_d = ST_P_AA;
			ST_P_AA:   if (mul_rsp.done) state_d = ST_P_OFF;
			ST_P_OFF:  if (mul_rsp.done) state_d = ST_P_BB;
			ST_P_BB:   if (mul_rsp.done) state_d = ST_E_CHK;
			ST_E_CHK:  state_d = e_pos ? ST_D_K0 : ST_RESULT;
			ST_D_K0:   if (div_rsp.done) state_d = ST_D_K1;
			ST_D_K1:   if (div_rsp.done) state_d = ST_C_BA;
			ST_C_BA:   if (mul_rsp.done) state_d = ST_C_BB;
			ST_C_BB:   if (mul_rsp.done) state_d = ST_C_AA;
			ST_C_AA:   if (mul_rsp.done) state_d = ST_C_AB;
			ST_C_AB:   if (mul_rsp.done) state_d = ST_C_ANG;
			ST_C_ANG:  if (mul_rsp.done) state_d = ST_C_BIAS;
			ST_C_BIAS: if (mul_rsp.done) state_d = ST_RESULT;
			ST_RESULT: if (!out_valid_q || !result_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall    = 1'b1;
		is_mul          = 1'b0;
		is_div          = 1'b0;
		out_load        = 1'b0;
		mul_req.x       = '0;
		mul_req.y       = MulYW'(dt_q);
		mul_req.neg     = 1'b0;
		mul_req.frac_hi = 1'b0;
		div_req.num     = aa_q;
		div_req.den     = e_q;
		case (state_q)
			ST_IDLE: sample_stall = 1'b0;
			ST_P_ANG: begin
				is_mul      = 1'b1;
				mul_req.x   = MulXW'(gb_mag);
				mul_req.neg = gb[StW];
			end
			ST_P_AA: begin
				is_mul      = 1'b1;
				mul_req.x   = MulXW'(daa_mag);
				mul_req.neg = daa[49];
			end
			ST_P_OFF: begin
				is_mul      = 1'b1;
				mul_req.x   = MulXW'(bb_mag);
				mul_req.neg = ~bb_q[CovW-1];
			end
			ST_P_BB: begin
				is_mul    = 1'b1;
				mul_req.x = MulXW'(qb_q);
			end
			ST_D_K0: is_div = 1'b1;
			ST_D_K1: begin
				is_div      = 1'b1;
				div_req.num = ba_q;
			end
			ST_C_BA: begin
				is_mul          = 1'b1;
				mul_req.x       = k1_mag_q;
				mul_req.y       = aa_mag;
				mul_req.neg     = ~(k1_neg_q ^ aa_q[CovW-1]);
				mul_req.frac_hi = 1'b1;
			end
			ST_C_BB: begin
				is_mul          = 1'b1;
				mul_req.x       = k1_mag_q;
				mul_req.y       = ab_mag;
				mul_req.neg     = ~(k1_neg_q ^ ab_q[CovW-1]);
				mul_req.frac_hi = 1'b1;
			end
			ST_C_AA: begin
				is_mul          = 1'b1;
				mul_req.x       = k0_mag_q;
				mul_req.y       = aa_mag;
				mul_req.neg     = ~(k0_neg_q ^ aa_q[CovW-1]);
				mul_req.frac_hi = 1'b1;
			end
			ST_C_AB: begin
				is_mul          = 1'b1;
				mul_req.x       = k0_mag_q;
				mul_req.y       = ab_mag;
				mul_req.neg     = ~(k0_neg_q ^ ab_q[CovW-1]);
				mul_req.frac_hi = 1'b1;
			end
			ST_C_ANG: begin
				is_mul          = 1'b1;
				mul_req.x       = k0_mag_q;
				mul_req.y       = MulYW'(innov_mag);
				mul_req.neg     = k0_neg_q ^ innov_q[StW];
				mul_req.frac_hi = 1'b1;
			end
			ST_C_BIAS: begin
				is_mul          = 1'b1;
				mul_req.x       = k1_mag_q;
				mul_req.y       = MulYW'(innov_mag);
				mul_req.neg     = k1_neg_q ^ innov_q[StW];
				mul_req.frac_hi = 1'b1;
			end
			ST_RESULT: out_load = !out_valid_q || !result_stall;
			default: sample_stall = 1'b1;
		endcase
		mul_req.start = is_mul && !phase_q;
		div_req.start = is_div && !phase_q;
	end

	assign accept    = sample_valid && !sample_stall;
	assign cfg_ready = 1'b1;

	kab_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	kab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			qa_q        <= QAngleRst;
			qb_q        <= QBiasRst;
			rm_q        <= RMeasRst;
			dt_q        <= DtRst;
			angle_q     <= '0;
			bias_q      <= '0;
			aa_q        <= CovOne;
			ab_q        <= '0;
			ba_q        <= '0;
			bb_q        <= CovOne;
		end else begin
			state_q <= state_d;
			if (mul_req.start || div_req.start)
				phase_q <= 1'b1;
			else if (mul_rsp.done || div_rsp.done)
				phase_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_Q_ANGLE: qa_q <= cfg_data;
					CFG_Q_BIAS:  qb_q <= cfg_data;
					CFG_R_MEAS:  rm_q <= cfg_data;
					CFG_STEP:    dt_q <= cfg_data[DtW-1:0];
					default:     dt_q <= dt_q;
				endcase
			end
			if (mul_rsp.done) begin
				case (state_q)
					ST_P_ANG:  angle_q <= sat_add32(angle_q, mul_rsp.res);
					ST_P_AA:   aa_q    <= sat_add48(aa_q, mul_rsp.res);
					ST_P_OFF: begin
						ab_q <= sat_add48(ab_q, mul_rsp.res);
						ba_q <= sat_add48(ba_q, mul_rsp.res);
					end
					ST_P_BB:   bb_q    <= sat_add48(bb_q, mul_rsp.res);
					ST_C_BA:   ba_q    <= sat_add48(ba_q, mul_rsp.res);
					ST_C_BB:   bb_q    <= sat_add48(bb_q, mul_rsp.res);
					ST_C_AA:   aa_q    <= sat_add48(aa_q, mul_rsp.res);
					ST_C_AB:   ab_q    <= sat_add48(ab_q, mul_rsp.res);
					ST_C_ANG:  angle_q <= sat_add32(angle_q, mul_rsp.res);
					ST_C_BIAS: bias_q  <= sat_add32(bias_q, mul_rsp.res);
					default:   bias_q  <= bias_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gyro_q  <= gyro_rate;
			accel_q <= accel_angle;
		end
		if (state_q == ST_E_CHK) begin
			e_q     <= e_sum[CovW-1:0];
			innov_q <= innov;
		end
		if (div_rsp.done && state_q == ST_D_K0) begin
			k0_mag_q <= div_rsp.mag;
			k0_neg_q <= div_rsp.neg;
		end
		if (div_rsp.done && state_q == ST_D_K1) begin
			k1_mag_q <= div_rsp.mag;
			k1_neg_q <= div_rsp.neg;
		end
		if (out_load) begin
			angle_out_q <= angle_q;
			rate_out_q  <= rate_sat;
		end
	end

	assign result_valid   = out_valid_q;
	assign angle_estimate = angle_out_q;
	assign rate_estimate  = rate_out_q;

endmodule

FILE: src/kab_checker.sv
`include "kalman_angle_bias_filter_assert.svh"

module kab_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_valid,
	input logic                           sample_stall,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic signed [kab_pkg::StW-1:0] angle_estimate,
	input logic signed [kab_pkg::StW-1:0] rate_estimate,
	input logic                           cfg_ready
);
	import kab_pkg::*;

	`KAB_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(angle_estimate) && $stable(rate_estimate))
	`KAB_ASSERT_NEXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall)
	`KAB_ASSERT_NOW(a_result_from_work, $rose(result_valid), $past(sample_stall))
	`KAB_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (.*);

FILE: dv/kalman_angle_bias_filter_tb.sv
module kalman_angle_bias_filter_tb;
	import kab_pkg::*;

	localparam longint Lim62 = longint'(1) << 62;
	localparam longint Max47 = (longint'(1) << 47) - 1;
	localparam int DrainCycles = 800;

	typedef struct {
		logic signed [StW-1:0] angle;
		logic signed [StW-1:0] rate;
	} estimate_t;

	typedef struct {
		logic signed [StW-1:0] gyro;
		logic signed [StW-1:0] accel;
		bit                    typed;
		logic signed [StW-1:0] angle;
		logic signed [StW-1:0] rate;
	} sample_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         sample_valid;
	logic                         sample_stall;
	logic signed [StW-1:0]        gyro_rate;
	logic signed [StW-1:0]        accel_angle;
	logic                         result_valid;
	logic                         result_stall;
	logic signed [StW-1:0]        angle_estimate;
	logic signed [StW-1:0]        rate_estimate;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CfgIdxW-1:0]           cfg_index;
	logic [NoiseW-1:0]            cfg_data;

	longint q_angle, q_bias, r_meas, dt;
	longint angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;
	estimate_t pending_estimates[$];
	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int hold_off = 0;
	bit rx_no_idle = 0;
	bit tx_no_idle = 0;
	logic signed [StW-1:0] last_accel = '0;

	kalman_angle_bias_filter u_top (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#150_000_000;
		$display("FAIL kalman_angle_bias_filter");
		$finish;
	end

	function automatic longint clamp_bits(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint rounded_product(longint a, longint b, int s);
		logic [127:0] p;
		logic [63:0]  x;
		logic [63:0]  y;
		bit           neg;
		neg = (a < 0) != (b < 0);
		x = (a < 0) ? 64'(-a) : 64'(a);
		y = (b < 0) ? 64'(-b) : 64'(b);
		p = {64'd0, x} * {64'd0, y};
		p = (p + (128'd1 << (s - 1))) >> s;
		if (p > 128'(Lim62))
			p = 128'(Lim62);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint rounded_gain(longint num, longint den);
		logic [127:0] n;
		logic [127:0] q;
		n = (num < 0) ? 128'(-num) : 128'(num);
		if (n / 128'(den) >= (128'd1 << 18))
			q = 128'(Lim62);
		else
			q = ((n << 45) + 128'(den)) / (128'(den) * 2);
		if (q > 128'(Lim62))
			q = 128'(Lim62);
		return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic estimate_t filter_step(logic signed [StW-1:0] g_in,
			logic signed [StW-1:0] a_in);
		longint g, a, d_aa, d_off, innov, e, k0, k1, t0, t1;
		estimate_t r;
		g = longint'(g_in);
		a = longint'(a_in);
		angle_st = clamp_bits(angle_st + rounded_product(g - bias_st, dt, 32), 32);
		d_aa = q_angle - p_ab - p_ba;
		d_off = -p_bb;
		p_aa = clamp_bits(p_aa + rounded_product(d_aa, dt, 32), 48);
		p_ab = clamp_bits(p_ab + rounded_product(d_off, dt, 32), 48);
		p_ba = clamp_bits(p_ba + rounded_product(d_off, dt, 32), 48);
		p_bb = clamp_bits(p_bb + rounded_product(q_bias, dt, 32), 48);
		innov = a - angle_st;
		e = r_meas + p_aa;
		if (e > 0) begin
			k0 = rounded_gain(p_aa, e);
			k1 = rounded_gain(p_ba, e);
			t0 = p_aa;
			t1 = p_ab;
			p_aa = clamp_bits(p_aa - rounded_product(k0, t0, 44), 48);
			p_ab = clamp_bits(p_ab - rounded_product(k0, t1, 44), 48);
			p_ba = clamp_bits(p_ba - rounded_product(k1, t0, 44), 48);
			p_bb = clamp_bits(p_bb - rounded_product(k1, t1, 44), 48);
			angle_st = clamp_bits(angle_st + rounded_product(k0, innov, 44), 32);
			bias_st = clamp_bits(bias_st + rounded_product(k1, innov, 44), 32);
		end
		r.angle = StW'(angle_st);
		r.rate = StW'(clamp_bits(g - bias_st, 32));
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [NoiseW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_Q_ANGLE: q_angle = longint'(value);
			CFG_Q_BIAS:  q_bias = longint'(value);
			CFG_R_MEAS:  r_meas = longint'(value);
			CFG_STEP:    dt = longint'(value[DtW-1:0]);
			default:     dt = dt;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_sample(logic signed [StW-1:0] g, logic signed [StW-1:0] a,
			bit typed, estimate_t typed_est);
		estimate_t est;
		int gap;
		sample_valid <= 1'b1;
		gyro_rate <= g;
		accel_angle <= a;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		est = filter_step(g, a);
		pending_estimates.push_back(typed ? typed_est : est);
		samples_sent++;
		last_accel = a;
		gap = tx_no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic signed [StW-1:0] g, a;
		int roll;
		estimate_t none;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			g = StW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			a = last_accel + StW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		end else if (roll < 90) begin
			g = $urandom;
			a = $urandom;
		end else begin
			g = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			a = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		end
		send_sample(g, a, 1'b0, none);
	endtask

	task automatic run_random(int count);
		repeat (count) send_random();
	endtask

	always @(posedge clk) begin
		estimate_t exp_est;
		if (result_valid && !result_stall) begin
			results_seen++;
			if (pending_estimates.size() == 0) begin
				$display("%0t: transaction with nothing expected, angle %0d rate %0d",
					$time, angle_estimate, rate_estimate);
				errors++;
			end else begin
				exp_est = pending_estimates.pop_front();
				if (angle_estimate !== exp_est.angle) begin
					$display("%0t: angle_estimate expected %0d actual %0d",
						$time, exp_est.angle, angle_estimate);
					errors++;
				end
				if (rate_estimate !== exp_est.rate) begin
					$display("%0t: rate_estimate expected %0d actual %0d",
						$time, exp_est.rate, rate_estimate);
					errors++;
				end
			end
		end
	end

	initial begin
		int stall_left;
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (!rx_no_idle)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		sample_row_t rows[$];
		estimate_t te;
		rows = '{
			'{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
			'{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
			'{32'sh7fffffff, 32'sh7fffffff, 1'b0, 0, 0},
			'{32'sh7fffffff, 32'sh7fffffff, 1'b0, 0, 0},
			'{32'sh80000000, 32'sh80000000, 1'b0, 0, 0},
			'{32'sh80000000, 32'sh80000000, 1'b0, 0, 0},
			'{32'sh7fffffff, 32'sh80000000, 1'b0, 0, 0},
			'{32'sh80000000, 32'sh7fffffff, 1'b0, 0, 0},
			'{32'shaaaaaaaa, 32'sh55555555, 1'b0, 0, 0},
			'{32'sh55555555, 32'shaaaaaaaa, 1'b0, 0, 0},
			'{32'sd65536, 32'sd0, 1'b0, 0, 0},
			'{-32'sd65536, 32'sd655360, 1'b0, 0, 0},
			'{32'sd1, -32'sd1, 1'b0, 0, 0},
			'{32'sd0, 32'sd0, 1'b0, 0, 0}
		};
		arst_n = 1'b0;
		sample_valid = 1'b0;
		gyro_rate = '0;
		accel_angle = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_Q_ANGLE;
		cfg_data = '0;
		q_angle = longint'(QAngleRst);
		q_bias = longint'(QBiasRst);
		r_meas = longint'(RMeasRst);
		dt = longint'(DtRst);
		angle_st = 0;
		bias_st = 0;
		p_aa = longint'(1) << 44;
		p_ab = 0;
		p_ba = 0;
		p_bb = longint'(1) << 44;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			te.angle = rows[i].angle;
			te.rate = rows[i].rate;
			send_sample(rows[i].gyro, rows[i].accel, rows[i].typed, te);
		end
		run_random(280);
		drain();

		// tiny noise, shortest step
		write_reg(CFG_Q_ANGLE, '0);
		write_reg(CFG_Q_BIAS, '0);
		write_reg(CFG_R_MEAS, NoiseW'(1));
		write_reg(CFG_STEP, NoiseW'(1));
		tx_no_idle = 1;
		rx_no_idle = 1;
		run_random(250);
		tx_no_idle = 0;
		rx_no_idle = 0;
		drain();

		// every register at its top
		write_reg(CFG_Q_ANGLE, NoiseW'(Max47));
		write_reg(CFG_Q_BIAS, NoiseW'(Max47));
		write_reg(CFG_R_MEAS, NoiseW'(Max47));
		write_reg(CFG_STEP, {15'h7fff, 32'hffffffff});
		run_random(250);
		drain();

		// fast step against tight measurement
		write_reg(CFG_Q_ANGLE, NoiseW'(Max47));
		write_reg(CFG_R_MEAS, NoiseW'(1));
		write_reg(CFG_STEP, NoiseW'(32'hffffffff));
		run_random(250);
		drain();

		write_reg(CFG_Q_ANGLE, NoiseW'({$urandom, $urandom}));
		write_reg(CFG_Q_BIAS, NoiseW'({$urandom, $urandom}));
		write_reg(CFG_R_MEAS, NoiseW'({$urandom, $urandom}) | NoiseW'(1));
		write_reg(CFG_STEP, NoiseW'($urandom_range(1, 32'h7fffffff)));
		run_random(20);
		hold_off = 4000;
		run_random(230);
		drain();

		write_reg(CFG_Q_ANGLE, QAngleRst);
		write_reg(CFG_Q_BIAS, QBiasRst);
		write_reg(CFG_R_MEAS, RMeasRst);
		write_reg(CFG_STEP, NoiseW'($urandom_range(1, 32'h0fffffff)));
		run_random(500);

		sample_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Ran %0d samples through %0d register writes across six noise settings,",
			samples_sent, cfg_writes);
		$display("checked %0d results with random gaps and one long output hold-off.",
			results_seen);
		if (errors == 0)
			$display("PASS kalman_angle_bias_filter");
		else
			$display("FAIL kalman_angle_bias_filter");
		$finish;
	end

endmodule
